// ===== rtl/core/dedge_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants of the directional edge detector.
// No dependencies; the top level, the front end and the back end import it.
package dedge_pkg;

  localparam int PIX_W     = 8;
  localparam int COL_W     = 10;
  localparam int ROW_W     = 12;
  localparam int ROWCNT_W  = 13;
  localparam int WIDTH_W   = 11;
  localparam int HEIGHT_W  = 13;
  localparam int THRESH_W  = 17;
  localparam int CEIL_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_ROWS      = 4096;

  // Three-pixel sum, sum of two of them, and the threshold product.
  localparam int SUM3_W    = PIX_W + 2;
  localparam int PAIR_W    = PIX_W + 3;
  localparam int REL_W     = THRESH_W + PAIR_W;
  localparam int FRAC_BITS = 16;
  localparam int NUM_DIRS  = 4;

  localparam int MQ_DEPTH = 4;
  localparam int OQ_DEPTH = 4;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(9830);
  localparam logic [CEIL_W-1:0]   CEIL_RESET   = CEIL_W'(1);
  localparam logic [PIX_W-1:0]    BORDER_RESET = PIX_W'(128);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_THRESHOLD_Q16 = 3'd2,
    CFG_CLAMP_CEILING = 3'd3,
    CFG_BORDER_VALUE  = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             pad;
  } in_word_t;

  typedef struct packed {
    logic             edge_res;
    logic [COL_W-1:0] column_index;
    logic [ROW_W-1:0] row_index;
    logic             frame_last;
  } out_word_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]  image_width;
    logic [HEIGHT_W-1:0] image_height;
    logic [THRESH_W-1:0] threshold_q16;
    logic [CEIL_W-1:0]   clamp_ceiling;
    logic [PIX_W-1:0]    border_value;
  } cfg_t;

  // Indexed [row][column]; row 0 is the top row, column 0 the left one.
  typedef logic [2:0][2:0][PIX_W-1:0] window_t;

  // One window handed from the front end to the back end.
  typedef struct packed {
    window_t          win;
    logic             emit_main;
    logic             emit_extra;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             frame_last;
  } task_t;

  function automatic logic [SUM3_W-1:0] sum3(input logic [PIX_W-1:0] p,
                                             input logic [PIX_W-1:0] q,
                                             input logic [PIX_W-1:0] r);
    return SUM3_W'(p) + SUM3_W'(q) + SUM3_W'(r);
  endfunction

endpackage

// ===== rtl/core/directional_edge_detector_3x3.sv =====
`timescale 1ns / 1ps
// Directional 3x3 relative-contrast edge detector, top level.
// Depends on dedge_pkg, dedge_fifo, dedge_front and dedge_back.

// Pixels enter in raster order at up to one per clock, each frame followed
// by one row of pad words. The result for pixel (x,y) leaves after pixel
// (x+1,y+1) has been taken; the pixel at the last column of a row yields two
// result words, which the contrast pipeline produces one after the other,
// while the first pixel of a row yields none, so a row of w pixels yields w
// result words and the block takes one pixel per clock as long as the result
// side pops every clock. A result word reaches the result port through the
// store-access stage, the window queue, two contrast test stages and the
// result queue after the pixel that completes its window is taken, and the
// second word of a last column follows it. After reset, full stays high while
// the line stores are filled with the reset border value; configuration
// writes are taken at any time and take effect at once, so change them only
// while no pixel is in flight.
module directional_edge_detector_3x3
  import dedge_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  in_word_t              item,
  output logic                  full,
  output logic                  empty,
  input  logic                  pop,
  output out_word_t             result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int MQ_CW = $clog2(MQ_DEPTH + 1);

  cfg_t             cfg;
  logic             task_push;
  task_t            task_in;
  task_t            task_head;
  logic             task_pop;
  logic             task_empty;
  logic             task_full;
  logic [MQ_CW-1:0] mq_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width   <= WIDTH_RESET;
      cfg.image_height  <= HEIGHT_RESET;
      cfg.threshold_q16 <= THRESH_RESET;
      cfg.clamp_ceiling <= CEIL_RESET;
      cfg.border_value  <= BORDER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          cfg.image_width <= cfg_data[WIDTH_W-1:0];
        end
        CFG_IMAGE_HEIGHT: begin
          cfg.image_height <= cfg_data[HEIGHT_W-1:0];
        end
        CFG_THRESHOLD_Q16: begin
          cfg.threshold_q16 <= cfg_data[THRESH_W-1:0];
        end
        CFG_CLAMP_CEILING: begin
          cfg.clamp_ceiling <= cfg_data[CEIL_W-1:0];
        end
        CFG_BORDER_VALUE: begin
          cfg.border_value <= cfg_data[PIX_W-1:0];
        end
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  dedge_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .cfg      (cfg),
    .mq_count (mq_count),
    .task_push(task_push),
    .task_word(task_in)
  );

  dedge_fifo #(
    .WIDTH($bits(task_t)),
    .DEPTH(MQ_DEPTH)
  ) u_window_queue (
    .clk  (clk),
    .rst  (rst),
    .push (task_push),
    .wdata(task_in),
    .pop  (task_pop),
    .rdata(task_head),
    .empty(task_empty),
    .full (task_full),
    .count(mq_count)
  );

  dedge_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .task_word (task_head),
    .task_empty(task_empty),
    .task_pop  (task_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    task_push |-> !task_full)
    else $error("window queue overflow");

endmodule

// ===== rtl/core/dedge_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module dedge_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/dedge_fifo.sv =====
`timescale 1ns / 1ps
// Small register FIFO with an occupancy count, used between the stages.
// Stand-alone; no package needed.
module dedge_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             push_ok;
  logic             pop_ok;

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push_ok, pop_ok})
        2'b10: begin
          count <= count + 1'b1;
        end
        2'b01: begin
          count <= count - 1'b1;
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/dedge_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts pixels, keeps the raster counters, the two line stores
// and the 3x3 window, and queues one window per item that yields results.
// Depends on dedge_pkg and dedge_ram.
module dedge_front
  import dedge_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  in_word_t                      item,
  output logic                          full,
  input  cfg_t                          cfg,
  input  logic [$clog2(MQ_DEPTH+1)-1:0] mq_count,
  output logic                          task_push,
  output task_t                         task_word
);

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int MW_W   = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W  = (MW_W > WIDTH_W) ? MW_W : WIDTH_W;
  localparam int MQ_CW  = $clog2(MQ_DEPTH + 1);
  localparam int OCC_W  = MQ_CW + 1;

  // Control state.
  logic                clr_busy;
  logic [AW-1:0]       clr_addr;
  logic [AW-1:0]       col_cnt;
  logic [ROWCNT_W-1:0] row_cnt;
  logic                f1_valid;

  // Item in the store-access stage.
  logic [AW-1:0]       f1_col;
  logic [ROWCNT_W-1:0] f1_row;
  logic [PIX_W-1:0]    f1_bot;
  logic                f1_last_col;
  logic                f1_pad_row;
  logic                f1_hz;
  logic [2*PIX_W-1:0]  f1_fwd;
  window_t             win;

  logic [CMP_W-1:0]    width_ext;
  logic [CMP_W-1:0]    w_eff;
  logic [CMP_W-1:0]    col_plus;
  logic [HEIGHT_W-1:0] h_eff;
  logic                last_col;
  logic                pad_row;
  logic                accept;
  logic [PIX_W-1:0]    bot;
  logic [OCC_W-1:0]    occ;

  logic [2*PIX_W-1:0]  ram_rdata;
  logic [2*PIX_W-1:0]  rd_word;
  logic [PIX_W-1:0]    st_upper;
  logic [PIX_W-1:0]    st_lower;
  logic [PIX_W-1:0]    top_pix;
  logic [PIX_W-1:0]    mid_pix;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [2*PIX_W-1:0]  ram_wdata;
  window_t             win_next;
  logic                emit_main;
  logic                emit_extra;

  // Effective geometry: width clamped to 1..MAX_WIDTH, height to 1..4096.
  always_comb begin
    width_ext = CMP_W'(cfg.image_width);
    if (width_ext == '0) begin
      w_eff = CMP_W'(1);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = width_ext;
    end
    if (cfg.image_height == '0) begin
      h_eff = HEIGHT_W'(1);
    end else if (cfg.image_height > HEIGHT_W'(MAX_ROWS)) begin
      h_eff = HEIGHT_W'(MAX_ROWS);
    end else begin
      h_eff = cfg.image_height;
    end
  end

  assign col_plus = CMP_W'(col_cnt) + CMP_W'(1);
  assign last_col = (col_plus >= w_eff);
  assign pad_row  = (row_cnt >= h_eff);

  // Room is reserved for the item in the store stage, so that stage never stalls.
  assign occ    = OCC_W'(mq_count) + OCC_W'(f1_valid);
  assign full   = clr_busy || (occ >= OCC_W'(MQ_DEPTH));
  assign accept = push && !full;
  assign bot    = (pad_row || item.pad) ? cfg.border_value : item.pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
      col_cnt  <= '0;
      row_cnt  <= '0;
      f1_valid <= 1'b0;
    end else begin
      if (clr_busy) begin
        if (clr_addr == AW'(MAX_WIDTH - 1)) begin
          clr_busy <= 1'b0;
        end
        clr_addr <= clr_addr + 1'b1;
      end
      f1_valid <= accept;
      if (accept) begin
        if (last_col) begin
          col_cnt <= '0;
          row_cnt <= pad_row ? '0 : row_cnt + 1'b1;
        end else begin
          col_cnt <= col_cnt + 1'b1;
        end
      end
    end
  end

  // Each store word holds {upper row, lower row} of one column.
  dedge_ram #(
    .WIDTH(2 * PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(col_cnt),
    .rdata(ram_rdata)
  );

  // The store reads the old word when the previous item writes the same column
  // in the same cycle (image width of one), so that word is forwarded instead.
  assign rd_word  = f1_hz ? f1_fwd : ram_rdata;
  assign st_upper = rd_word[2*PIX_W-1:PIX_W];
  assign st_lower = rd_word[PIX_W-1:0];
  assign top_pix  = (f1_row >= ROWCNT_W'(2)) ? st_upper : cfg.border_value;
  assign mid_pix  = (f1_row >= ROWCNT_W'(1)) ? st_lower : cfg.border_value;

  assign ram_we    = clr_busy || f1_valid;
  assign ram_waddr = clr_busy ? clr_addr : f1_col;
  assign ram_wdata = clr_busy ? {BORDER_RESET, BORDER_RESET} : {st_lower, f1_bot};

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_col      <= col_cnt;
      f1_row      <= row_cnt;
      f1_bot      <= bot;
      f1_last_col <= last_col;
      f1_pad_row  <= pad_row;
      f1_hz       <= f1_valid && (f1_col == col_cnt);
      f1_fwd      <= ram_wdata;
    end
    if (f1_valid) begin
      win <= win_next;
    end
  end

  always_comb begin
    win_next = win;
    for (int i = 0; i < 3; i++) begin
      if (f1_col == '0) begin
        win_next[i][0] = cfg.border_value;
        win_next[i][1] = cfg.border_value;
      end else begin
        win_next[i][0] = win[i][1];
        win_next[i][1] = win[i][2];
      end
    end
    win_next[0][2] = top_pix;
    win_next[1][2] = mid_pix;
    win_next[2][2] = f1_bot;
  end

  assign emit_main  = (f1_row != '0) && (f1_col != '0);
  assign emit_extra = (f1_row != '0) && f1_last_col;
  assign task_push  = f1_valid && (emit_main || emit_extra);

  always_comb begin
    task_word.win        = win_next;
    task_word.emit_main  = emit_main;
    task_word.emit_extra = emit_extra;
    task_word.col        = COL_W'(f1_col);
    task_word.row        = ROW_W'(f1_row - ROWCNT_W'(1));
    task_word.frame_last = f1_pad_row;
  end

  a_no_item_during_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !f1_valid)
    else $error("item reached the line stores during the clearing pass");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    task_push |-> (mq_count < MQ_CW'(MQ_DEPTH)))
    else $error("window pushed into a full queue");

  a_forward_source: assert property (@(posedge clk) disable iff (rst)
    (f1_valid && f1_hz) |-> $past(f1_valid))
    else $error("store forwarding without a preceding write");

endmodule

// ===== rtl/core/dedge_back.sv =====
`timescale 1ns / 1ps
// Back end: takes queued windows, runs the four directional contrast tests
// in a two-stage pipeline and holds finished words in the result queue.
// Depends on dedge_pkg and dedge_fifo.
module dedge_back
  import dedge_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  task_t     task_word,
  input  logic      task_empty,
  output logic      task_pop,
  output logic      empty,
  input  logic      pop,
  output out_word_t result
);

  localparam int OQ_CW = $clog2(OQ_DEPTH + 1);
  localparam int CR_W  = OQ_CW + 1;

  logic                   phase;
  logic                   s1_v;
  logic                   s2_v;
  out_word_t              s1_meta;
  out_word_t              s2_meta;
  logic [SUM3_W-1:0]      s1_diff [NUM_DIRS];
  logic [PAIR_W-1:0]      s1_sum  [NUM_DIRS];
  logic [SUM3_W-1:0]      s2_diff [NUM_DIRS];
  logic [REL_W-1:0]       s2_rel  [NUM_DIRS];

  logic [OQ_CW-1:0]       oq_count;
  logic                   oq_full;
  logic [CR_W-1:0]        pending;
  logic                   issue;
  logic                   use_main;
  window_t                w;
  out_word_t              meta;
  logic [SUM3_W-1:0]      sa [NUM_DIRS];
  logic [SUM3_W-1:0]      sb [NUM_DIRS];
  logic [REL_W-1:0]       cap;
  logic [REL_W-1:0]       lhs;
  logic [REL_W-1:0]       lim;
  logic [NUM_DIRS-1:0]    hit;
  out_word_t              oq_wdata;

  // Words in the result queue plus words in flight must fit in the queue.
  assign pending  = CR_W'(oq_count) + CR_W'(s1_v) + CR_W'(s2_v);
  assign issue    = !task_empty && (pending < CR_W'(OQ_DEPTH));
  assign use_main = !phase && task_word.emit_main;
  assign task_pop = issue && !(use_main && task_word.emit_extra);

  // The extra word at the last column sees the window moved one column left
  // with border pixels on the right.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (use_main) begin
        w[i] = task_word.win[i];
      end else begin
        w[i][0] = task_word.win[i][1];
        w[i][1] = task_word.win[i][2];
        w[i][2] = cfg.border_value;
      end
    end
    meta.edge_res     = 1'b0;
    meta.column_index = use_main ? task_word.col - 1'b1 : task_word.col;
    meta.row_index    = task_word.row;
    meta.frame_last   = use_main ? 1'b0 : task_word.frame_last;

    sa[0] = sum3(w[0][0], w[1][0], w[2][0]);
    sb[0] = sum3(w[0][2], w[1][2], w[2][2]);
    sa[1] = sum3(w[0][0], w[0][1], w[0][2]);
    sb[1] = sum3(w[2][0], w[2][1], w[2][2]);
    sa[2] = sum3(w[0][0], w[0][1], w[1][0]);
    sb[2] = sum3(w[1][2], w[2][1], w[2][2]);
    sa[3] = sum3(w[2][0], w[2][1], w[1][0]);
    sb[3] = sum3(w[0][1], w[0][2], w[1][2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
    end else begin
      if (issue) begin
        phase <= use_main && task_word.emit_extra;
      end
      s1_v <= issue;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_meta <= meta;
      for (int k = 0; k < NUM_DIRS; k++) begin
        s1_diff[k] <= (sa[k] > sb[k]) ? sa[k] - sb[k] : sb[k] - sa[k];
        s1_sum[k]  <= PAIR_W'(sa[k]) + PAIR_W'(sb[k]);
      end
    end
    if (s1_v) begin
      s2_meta <= s1_meta;
      for (int k = 0; k < NUM_DIRS; k++) begin
        s2_diff[k] <= s1_diff[k];
        s2_rel[k]  <= REL_W'(cfg.threshold_q16) * REL_W'(s1_sum[k]);
      end
    end
  end

  // A direction fires when 2*|A-B|*2^16 > min(T*(A+B), 6*ceiling*2^16).
  always_comb begin
    cap = ((REL_W'(cfg.clamp_ceiling) << 2) + (REL_W'(cfg.clamp_ceiling) << 1))
          << FRAC_BITS;
    lhs = '0;
    lim = '0;
    for (int k = 0; k < NUM_DIRS; k++) begin
      lhs    = REL_W'(s2_diff[k]) << (FRAC_BITS + 1);
      lim    = (s2_rel[k] < cap) ? s2_rel[k] : cap;
      hit[k] = (lhs > lim);
    end
    oq_wdata          = s2_meta;
    oq_wdata.edge_res = |hit;
  end

  dedge_fifo #(
    .WIDTH($bits(out_word_t)),
    .DEPTH(OQ_DEPTH)
  ) u_result_queue (
    .clk  (clk),
    .rst  (rst),
    .push (s2_v),
    .wdata(oq_wdata),
    .pop  (pop),
    .rdata(result),
    .empty(empty),
    .full (oq_full),
    .count(oq_count)
  );

  a_result_room: assert property (@(posedge clk) disable iff (rst)
    s2_v |-> !oq_full)
    else $error("finished word pushed into a full result queue");

  a_second_half: assert property (@(posedge clk) disable iff (rst)
    phase |-> (!task_empty && task_word.emit_main && task_word.emit_extra))
    else $error("second word pending without a two-word window at the head");

  a_pop_on_issue: assert property (@(posedge clk) disable iff (rst)
    task_pop |-> issue)
    else $error("window dropped from the queue without being issued");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for directional_edge_detector_3x3: directed and random pixel
// frames are checked against a window model kept inside the bench.
// Depends on dedge_pkg and the detector RTL.
module tb;
  import dedge_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(CFG_BORDER_VALUE) + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  in_word_t              item = '0;
  logic                  full;
  logic                  empty;
  logic                  pop = 1'b0;
  out_word_t             result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Model of the line stores, the window, the raster position and the registers.
  logic [PIX_W-1:0]    upper_line [MAX_WIDTH_DEF];
  logic [PIX_W-1:0]    lower_line [MAX_WIDTH_DEF];
  window_t             win;
  int unsigned         col_cnt;
  int unsigned         row_cnt;
  logic [WIDTH_W-1:0]  m_width = WIDTH_RESET;
  logic [HEIGHT_W-1:0] m_height = HEIGHT_RESET;
  logic [THRESH_W-1:0] m_thresh = THRESH_RESET;
  logic [CEIL_W-1:0]   m_ceiling = CEIL_RESET;
  logic [PIX_W-1:0]    m_border = BORDER_RESET;

  in_word_t    pixel_queue[$];
  out_word_t   edge_queue[$];
  int unsigned queued_pixels = 0;
  int unsigned taken_pixels = 0;
  int unsigned error_count = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;

  always #2 clk = ~clk;

  directional_edge_detector_3x3 u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic int unsigned eff_width();
    int unsigned w;
    w = m_width;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = m_height;
    if (h < 1) h = 1;
    if (h > MAX_ROWS) h = MAX_ROWS;
    return h;
  endfunction

  function automatic int unsigned tri_sum(logic [PIX_W-1:0] p, logic [PIX_W-1:0] q,
                                          logic [PIX_W-1:0] r);
    return int'(p) + int'(q) + int'(r);
  endfunction

  // Exact integer form of |A-B|/3 > clamp(t*(A+B)/6, 0, ceiling), scaled by 6*2^16.
  function automatic bit contrast(int unsigned a, int unsigned b);
    longint unsigned diff, lhs, rel, cap, lim;
    diff = (a > b) ? 64'(a - b) : 64'(b - a);
    lhs  = diff * 64'd131072;
    rel  = 64'(m_thresh) * 64'(a + b);
    cap  = 64'(m_ceiling) * 64'd393216;
    lim  = (rel < cap) ? rel : cap;
    return lhs > lim;
  endfunction

  function automatic bit edge_of(window_t w);
    bit hit;
    hit = contrast(tri_sum(w[0][0], w[1][0], w[2][0]), tri_sum(w[0][2], w[1][2], w[2][2]));
    hit |= contrast(tri_sum(w[0][0], w[0][1], w[0][2]), tri_sum(w[2][0], w[2][1], w[2][2]));
    hit |= contrast(tri_sum(w[0][0], w[0][1], w[1][0]), tri_sum(w[1][2], w[2][1], w[2][2]));
    hit |= contrast(tri_sum(w[2][0], w[2][1], w[1][0]), tri_sum(w[0][1], w[0][2], w[1][2]));
    return hit;
  endfunction

  function automatic int unsigned items_to_frame_end();
    int unsigned w, h, in_row;
    w = eff_width();
    h = eff_height();
    in_row = (col_cnt + 1 >= w) ? 1 : w - col_cnt;
    if (row_cnt >= h) return in_row;
    return in_row + (h - row_cnt) * w;
  endfunction

  // Advances the model by one taken pixel word and records the results it causes.
  task automatic track_pixel(in_word_t px);
    int unsigned      w, h, c, r;
    int               i;
    logic [PIX_W-1:0] top_px, mid_px, bot_px;
    bit               last_col, pad_row;
    window_t          tail;
    out_word_t        res;
    w = eff_width();
    h = eff_height();
    c = col_cnt;
    r = row_cnt;
    last_col = (c + 1 >= w);
    pad_row = (r >= h);
    bot_px = (pad_row || px.pad) ? m_border : px.pixel;
    top_px = m_border;
    mid_px = m_border;
    if (c < MAX_WIDTH_DEF) begin
      // Rows above the image come from the row position, never from the stores.
      if (r >= 2) top_px = upper_line[c];
      if (r >= 1) mid_px = lower_line[c];
      upper_line[c] = lower_line[c];
      lower_line[c] = bot_px;
    end
    for (i = 0; i < 3; i++) begin
      if (c == 0) begin
        win[i][0] = m_border;
        win[i][1] = m_border;
      end else begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
    end
    win[0][2] = top_px;
    win[1][2] = mid_px;
    win[2][2] = bot_px;
    if (r >= 1) begin
      if (c >= 1) begin
        res.edge_res     = edge_of(win);
        res.column_index = COL_W'(c - 1);
        res.row_index    = ROW_W'(r - 1);
        res.frame_last   = 1'b0;
        edge_queue.push_back(res);
      end
      if (last_col) begin
        // The last column is judged with a border column to its right.
        for (i = 0; i < 3; i++) begin
          tail[i][0] = win[i][1];
          tail[i][1] = win[i][2];
          tail[i][2] = m_border;
        end
        res.edge_res     = edge_of(tail);
        res.column_index = COL_W'(c);
        res.row_index    = ROW_W'(r - 1);
        res.frame_last   = pad_row;
        edge_queue.push_back(res);
      end
    end
    if (last_col) begin
      col_cnt = 0;
      row_cnt = pad_row ? 0 : ((r + 1) & 32'h1FFF);
    end else begin
      col_cnt = (c + 1) & 32'h3FF;
    end
  endtask

  // Pixel driver: holds a word until it is taken, then fetches the next one.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        track_pixel(item);
        taken_pixels++;
      end
      if (!push || !full) begin
        if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          push <= 1'b1;
          item <= pixel_queue.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin : monitor
    out_word_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (edge_queue.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, got edge=%0d col=%0d row=%0d last=%0d", $time,
                   result.edge_res, result.column_index, result.row_index, result.frame_last);
        end else begin
          want = edge_queue.pop_front();
          if (result.edge_res !== want.edge_res || result.column_index !== want.column_index ||
              result.row_index !== want.row_index || result.frame_last !== want.frame_last) begin
            error_count++;
            $display("%0t: mismatch, expected edge=%0d col=%0d row=%0d last=%0d, got edge=%0d col=%0d row=%0d last=%0d",
                     $time, want.edge_res, want.column_index, want.row_index, want.frame_last,
                     result.edge_res, result.column_index, result.row_index, result.frame_last);
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_IMAGE_WIDTH:   m_width   = WIDTH_W'(value);
      CFG_IMAGE_HEIGHT:  m_height  = HEIGHT_W'(value);
      CFG_THRESHOLD_Q16: m_thresh  = THRESH_W'(value);
      CFG_CLAMP_CEILING: m_ceiling = CEIL_W'(value);
      CFG_BORDER_VALUE:  m_border  = PIX_W'(value);
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned w, int unsigned h, int unsigned thr,
                            int unsigned ceiling, int unsigned border);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_THRESHOLD_Q16, thr);
    write_reg(CFG_CLAMP_CEILING, ceiling);
    write_reg(CFG_BORDER_VALUE, border);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_pixel(int unsigned value, bit pad);
    in_word_t px;
    px.pixel = PIX_W'(value);
    px.pad   = pad;
    pixel_queue.push_back(px);
    queued_pixels++;
  endtask

  task automatic add_random(int unsigned count);
    int unsigned k, sel;
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) add_pixel(0, $urandom_range(0, 11) == 0);
      else if (sel == 1) add_pixel(255, $urandom_range(0, 11) == 0);
      else add_pixel($urandom_range(0, 255), $urandom_range(0, 11) == 0);
    end
  endtask

  // Registers may only change once every word is taken and every result is out.
  task automatic drain();
    while (taken_pixels != queued_pixels || edge_queue.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  initial begin : stimulus
    int          i;
    int unsigned sent, count, w, h, thr, ceiling, sel;
    for (i = 0; i < MAX_WIDTH_DEF; i++) begin
      upper_line[i] = BORDER_RESET;
      lower_line[i] = BORDER_RESET;
    end
    win = {9{BORDER_RESET}};
    col_cnt = 0;
    row_cnt = 0;
    send_idle = 26;
    recv_idle = 88;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // The line stores are cleared after reset; nothing is accepted until then.
    while (full) @(posedge clk);

    // Width of three, zero threshold and ceiling, dark border.
    set_config(3, 1, 0, 0, 0);
    add_pixel(0, 0);   add_pixel(255, 0); add_pixel(0, 0);
    add_pixel(255, 1); add_pixel(0, 0);   add_pixel(255, 0);
    drain();

    // Writes outside the register list must leave the settings alone.
    write_reg(CFG_SPARE_LO, 32'h1FFFF);
    write_reg(CFG_SPARE_HI, 32'h1FFFF);
    set_config(4, 2, 32'h1FFFF, 255, 255);
    add_pixel(255, 0); add_pixel(0, 0);   add_pixel(255, 0); add_pixel(0, 0);
    add_pixel(0, 1);   add_pixel(255, 0); add_pixel(0, 0);   add_pixel(255, 1);
    add_random(4);
    drain();

    // Zero width and height act as one.
    set_config(0, 0, 65536, 128, 0);
    add_pixel(255, 0); add_pixel(77, 0);
    drain();

    set_config(2, 1, 0, 255, 128);
    add_pixel(0, 0); add_pixel(255, 0); add_pixel(255, 1); add_pixel(0, 0);
    drain();

    // Oversize width and height; the frame is left open a few words into the first row.
    send_idle = 0;
    recv_idle = 0;
    set_config(2047, 8191, 9830, 1, 128);
    add_random(12);
    drain();

    // The column counter now sits past the new width.
    set_config(5, 1, 20000, 40, 60);
    add_random(items_to_frame_end() + 2 * 5);
    drain();

    sent = 0;
    while (sent < 700) begin
      if (sent < 233) begin
        send_idle = 26;
        recv_idle = 88;
      end else if (sent < 466) begin
        send_idle = 88;
        recv_idle = 26;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      sel = $urandom_range(0, 19);
      if (sel == 0) w = $urandom_range(0, 2);
      else if (sel == 1) w = $urandom_range(9, 24);
      else w = $urandom_range(3, 8);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
      sel = $urandom_range(0, 9);
      if (sel == 0) thr = 0;
      else if (sel == 1) thr = 65536;
      else if (sel == 2) thr = $urandom_range(65537, 131071);
      else thr = $urandom_range(0, 30000);
      ceiling = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 60);
      set_config(w, h, thr, ceiling, $urandom_range(0, 255));
      count = items_to_frame_end() + ($urandom_range(1, 2) - 1) * (eff_height() + 1) * eff_width();
      // Now and then a frame is cut short and the next settings start mid-frame.
      if ($urandom_range(0, 7) == 0) count = $urandom_range(1, count);
      add_random(count);
      sent += count;
      drain();
    end

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
